FILE: hw/rtl/boc_pkg.sv
`timescale 1ns / 1ps

package boc_pkg;

  // Fixed result format: unsigned Q1.16 cost
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COST_BITS = FRAC_BITS + 1;
  localparam logic [COST_BITS-1:0] ONE_Q16  = COST_BITS'(1) << FRAC_BITS;
  localparam logic [COST_BITS-1:0] INF_CODE = {COST_BITS{1'b1}};

  // Width of the frames-since-update count
  localparam int unsigned AGE_BITS = 8;

  // One restoring quotient bit per divider stage
  localparam int unsigned DIV_STEPS = COST_BITS;

  // Registers from accepted item to result strobe:
  // edges, extents/areas, products, union, divider steps, output register
  localparam int unsigned PIPE_LATENCY = 4 + DIV_STEPS + 1;

endpackage

FILE: hw/rtl/box_overlap_cost.sv
`timescale 1ns / 1ps

// Overlap cost for one track/detection box pair per item: cost = 1 - IoU in
// unsigned Q1.16, IoU truncated. An item is taken in every cycle that start is
// high; busy is never raised. Each result appears on done_o once its item has
// passed the stages named below and must be captured in that cycle. Each item
// passes the divider: 17 pipeline stages that each resolve one quotient bit of
// intersection * 2^16 / union, after four stages of edge, extent, area and
// union arithmetic and before one output register. Stale tracks return the
// infinite cost code 131071; a zero union returns cost 1.0 with
// degenerate_union_o set.
module box_overlap_cost #(
  parameter int unsigned COORD_BITS  = 14,
  parameter int unsigned TAG_BITS    = 8,
  parameter int unsigned STALE_LIMIT = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [TAG_BITS-1:0]             row_tag_i,
  input  logic [TAG_BITS-1:0]             col_tag_i,
  input  logic signed [COORD_BITS-1:0]    track_left_i,
  input  logic signed [COORD_BITS-1:0]    track_top_i,
  input  logic [COORD_BITS-2:0]           track_width_i,
  input  logic [COORD_BITS-2:0]           track_height_i,
  input  logic [boc_pkg::AGE_BITS-1:0]    frames_since_update_i,
  input  logic signed [COORD_BITS-1:0]    det_left_i,
  input  logic signed [COORD_BITS-1:0]    det_top_i,
  input  logic [COORD_BITS-2:0]           det_width_i,
  input  logic [COORD_BITS-2:0]           det_height_i,
  output logic                            done_o,
  output logic [TAG_BITS-1:0]             out_row_tag_o,
  output logic [TAG_BITS-1:0]             out_col_tag_o,
  output logic [boc_pkg::COST_BITS-1:0]   cost_q16_o,
  output logic                            infinite_cost_o,
  output logic                            degenerate_union_o
);

  localparam int unsigned SW = COORD_BITS - 1;  // box size
  localparam int unsigned EW = COORD_BITS + 1;  // right/bottom edge, signed
  localparam int unsigned DW = EW + 1;          // extent difference, signed
  localparam int unsigned AW = 2 * SW;          // area
  localparam int unsigned UW = AW + 1;          // area sum and union
  localparam int unsigned CB = boc_pkg::COST_BITS;
  localparam int unsigned NS = boc_pkg::DIV_STEPS;

  // Sideband that travels with each item
  typedef struct packed {
    logic                stale;
    logic                degen;
    logic [TAG_BITS-1:0] row;
    logic [TAG_BITS-1:0] col;
  } side_t;

  // The pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: far edges, overlap bounds, staleness
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0]        tr_x, tr_y, dr_x, dr_y;
  logic signed [EW-1:0]        min_r_x_d, min_r_y_d;
  logic signed [COORD_BITS-1:0] max_l_x_d, max_l_y_d;
  logic signed [EW-1:0]        min_r_x_q, min_r_y_q;
  logic signed [COORD_BITS-1:0] max_l_x_q, max_l_y_q;
  logic [SW-1:0]               tw_q, th_q, dw_q, dh_q;
  side_t                       s1_side_d, s1_side_q;
  logic                        s1_vld_q;

  always_comb begin
    tr_x = EW'(track_left_i) + $signed({2'b00, track_width_i});
    tr_y = EW'(track_top_i) + $signed({2'b00, track_height_i});
    dr_x = EW'(det_left_i) + $signed({2'b00, det_width_i});
    dr_y = EW'(det_top_i) + $signed({2'b00, det_height_i});
    min_r_x_d = (tr_x < dr_x) ? tr_x : dr_x;
    min_r_y_d = (tr_y < dr_y) ? tr_y : dr_y;
    max_l_x_d = (track_left_i > det_left_i) ? track_left_i : det_left_i;
    max_l_y_d = (track_top_i > det_top_i) ? track_top_i : det_top_i;
    s1_side_d.stale = frames_since_update_i > boc_pkg::AGE_BITS'(STALE_LIMIT);
    s1_side_d.degen = 1'b0;
    s1_side_d.row   = row_tag_i;
    s1_side_d.col   = col_tag_i;
  end

  always_ff @(posedge clk_i) begin
    min_r_x_q <= min_r_x_d;
    min_r_y_q <= min_r_y_d;
    max_l_x_q <= max_l_x_d;
    max_l_y_q <= max_l_y_d;
    tw_q      <= track_width_i;
    th_q      <= track_height_i;
    dw_q      <= det_width_i;
    dh_q      <= det_height_i;
    s1_side_q <= s1_side_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clamped overlap extents, box areas
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] ext_x, ext_y;
  logic [SW-1:0]        ix_d, iy_d, ix_q, iy_q;
  logic [AW-1:0]        area_t_q, area_d_q;
  side_t                s2_side_q;
  logic                 s2_vld_q;

  always_comb begin
    ext_x = DW'(min_r_x_q) - DW'(max_l_x_q);
    ext_y = DW'(min_r_y_q) - DW'(max_l_y_q);
    // Disjoint or touching boxes give zero extent
    ix_d  = ext_x[DW-1] ? '0 : ext_x[SW-1:0];
    iy_d  = ext_y[DW-1] ? '0 : ext_y[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    ix_q      <= ix_d;
    iy_q      <= iy_d;
    area_t_q  <= AW'(tw_q) * AW'(th_q);
    area_d_q  <= AW'(dw_q) * AW'(dh_q);
    s2_side_q <= s1_side_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: intersection area, area sum
  // ---------------------------------------------------------------------------
  logic [AW-1:0] inter_q;
  logic [UW-1:0] area_sum_q;
  side_t         s3_side_q;
  logic          s3_vld_q;

  always_ff @(posedge clk_i) begin
    inter_q    <= AW'(ix_q) * AW'(iy_q);
    area_sum_q <= UW'(area_t_q) + UW'(area_d_q);
    s3_side_q  <= s2_side_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: union area, zero-union detect
  // ---------------------------------------------------------------------------
  logic [UW-1:0] uni_d, uni_q;
  logic [AW-1:0] inter4_q;
  side_t         s4_side_d, s4_side_q;
  logic          s4_vld_q;

  always_comb begin
    uni_d           = area_sum_q - UW'(inter_q);
    s4_side_d       = s3_side_q;
    s4_side_d.degen = (uni_d == '0);
  end

  always_ff @(posedge clk_i) begin
    uni_q     <= uni_d;
    inter4_q  <= inter_q;
    s4_side_q <= s4_side_d;
  end

  // ---------------------------------------------------------------------------
  // Divider: one restoring quotient bit per stage, MSB first.
  // Intersection never exceeds the union, so the remainder stays below it.
  // ---------------------------------------------------------------------------
  logic [UW-1:0] rem_q [NS];
  logic [UW-1:0] div_uni_q [NS];
  logic [CB-1:0] quo_q [NS];
  side_t         div_side_q [NS];
  logic          div_vld_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [UW:0]   trial;
    logic          qbit;
    logic [UW-1:0] rem_d;
    logic [CB-1:0] quo_d;
    logic [UW-1:0] uni_in;
    side_t         side_in;

    if (k == 0) begin : g_first
      assign trial   = {1'b0, UW'(inter4_q)};
      assign uni_in  = uni_q;
      assign side_in = s4_side_q;
      assign quo_d   = {{(CB-1){1'b0}}, qbit};
    end else begin : g_next
      assign trial   = {rem_q[k-1], 1'b0};
      assign uni_in  = div_uni_q[k-1];
      assign side_in = div_side_q[k-1];
      assign quo_d   = {quo_q[k-1][CB-2:0], qbit};
    end

    // Subtract the union where it fits
    always_comb begin
      qbit  = (trial >= {1'b0, uni_in});
      rem_d = qbit ? UW'(trial - {1'b0, uni_in}) : trial[UW-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]      <= rem_d;
      quo_q[k]      <= quo_d;
      div_uni_q[k]  <= uni_in;
      div_side_q[k] <= side_in;
    end

    // Advance the valid bit
    if (k == 0) begin : g_vld_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          div_vld_q[k] <= 1'b0;
        end else begin
          div_vld_q[k] <= s4_vld_q;
        end
      end
    end else begin : g_vld_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          div_vld_q[k] <= 1'b0;
        end else begin
          div_vld_q[k] <= div_vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: special codes, then 1 - IoU
  // ---------------------------------------------------------------------------
  logic [CB-1:0] iou_sat;
  logic [CB-1:0] cost_d, cost_q;
  side_t         out_side;
  logic          done_q;
  logic [TAG_BITS-1:0] row_q, col_q;
  logic          inf_q, degen_q;

  always_comb begin
    out_side = div_side_q[NS-1];
    iou_sat  = (quo_q[NS-1] > boc_pkg::ONE_Q16) ? boc_pkg::ONE_Q16 : quo_q[NS-1];
    if (out_side.stale) begin
      cost_d = boc_pkg::INF_CODE;
    end else if (out_side.degen) begin
      cost_d = boc_pkg::ONE_Q16;
    end else begin
      cost_d = boc_pkg::ONE_Q16 - iou_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q  <= cost_d;
    row_q   <= out_side.row;
    col_q   <= out_side.col;
    inf_q   <= out_side.stale;
    degen_q <= out_side.degen & ~out_side.stale;
  end

  // Valid bits of the front stages and the output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start & ~busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      done_q   <= div_vld_q[NS-1];
    end
  end

  assign done_o             = done_q;
  assign out_row_tag_o      = row_q;
  assign out_col_tag_o      = col_q;
  assign cost_q16_o         = cost_q;
  assign infinite_cost_o    = inf_q;
  assign degenerate_union_o = degen_q;

endmodule

FILE: hw/rtl/boc_checker.sv
`timescale 1ns / 1ps

module boc_checker #(
  parameter int unsigned TAG_BITS = 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [TAG_BITS-1:0]           row_tag_i,
  input logic [TAG_BITS-1:0]           col_tag_i,
  input logic                          done_o,
  input logic [TAG_BITS-1:0]           out_row_tag_o,
  input logic [TAG_BITS-1:0]           out_col_tag_o,
  input logic [boc_pkg::COST_BITS-1:0] cost_q16_o,
  input logic                          infinite_cost_o,
  input logic                          degenerate_union_o
);

  localparam int unsigned LAT = boc_pkg::PIPE_LATENCY;

  // Every result traces back to an item taken a fixed latency earlier
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  // Tags come back unchanged with their item
  a_tags_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_row_tag_o == $past(row_tag_i, LAT)) &&
               (out_col_tag_o == $past(col_tag_i, LAT)))
    else $error("tags do not match the item");

  // Stale track carries the infinite code and no degenerate flag
  a_infinite_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && infinite_cost_o) |->
      (cost_q16_o == boc_pkg::INF_CODE) && !degenerate_union_o)
    else $error("infinite cost flag with wrong code");

  // Degenerate union gives cost 1.0; normal cost never exceeds 1.0
  a_cost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !infinite_cost_o) |->
      (cost_q16_o <= boc_pkg::ONE_Q16) &&
      (!degenerate_union_o || (cost_q16_o == boc_pkg::ONE_Q16)))
    else $error("finite cost out of range");

endmodule

bind box_overlap_cost boc_checker #(.TAG_BITS(TAG_BITS)) u_boc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .row_tag_i          (row_tag_i),
  .col_tag_i          (col_tag_i),
  .done_o             (done_o),
  .out_row_tag_o      (out_row_tag_o),
  .out_col_tag_o      (out_col_tag_o),
  .cost_q16_o         (cost_q16_o),
  .infinite_cost_o    (infinite_cost_o),
  .degenerate_union_o (degenerate_union_o)
);
